>>> hdl/nrp_pkg.sv
// Package for the NMEA sentence parser with baud probe.
// Types, codes and a helper function shared by the front, queue and back modules.
package nrp_pkg;

    localparam int LINE_MAX = 128;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [2:0] ST_REJECT = 3'd0;
    localparam logic [2:0] ST_RMC    = 3'd1;
    localparam logic [2:0] ST_GGA    = 3'd2;
    localparam logic [2:0] ST_OTHER  = 3'd3;
    localparam logic [2:0] ST_BAUD   = 3'd4;

    localparam logic CFG_WINDOW  = 1'b0;
    localparam logic CFG_PRELOAD = 1'b1;

    localparam logic [23:0] TAG_RMC = 24'h524D43;
    localparam logic [23:0] TAG_GGA = 24'h474741;

    typedef enum logic [1:0] {
        K_LINE = 2'd0,
        K_BAUD = 2'd1
    } t_kind;

    // finished line or baud switch summary passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        good;
        logic        is_rmc;
        logic        is_gga;
        logic [23:0] tcap;
        logic [23:0] dcap;
        logic        active;
        logic        sat_upd;
        logic [7:0]  sat_val;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic [40:0] fix;
        logic [7:0]  sat;
        logic        fast;
        logic        locked;
        logic        changed;
    } t_res;

    // state shared back to the front for the probe
    typedef struct packed {
        logic locked;
        logic fast;
    } t_lock;

    function automatic logic [3:0] cap_dig(input logic [23:0] c, input int p);
        logic [3:0] n;
        n = c[20-4*p +: 4];
        return (n >= 4'd1 && n <= 4'd10) ? n - 4'd1 : 4'd15;
    endfunction

endpackage

>>> hdl/nmea_rmc_gga_parser_baud_probe.sv
// Top level of the NMEA sentence parser with baud probe.
// Instantiates nrp_front, nrp_queue and nrp_back; uses nrp_pkg.
//
// Usage:
//  Input channel (i_valid/o_stall): one item per cycle while not stalled,
//  either a received byte (i_operation 0) or a millisecond tick
//  (i_operation 1). The front tracks the line, checksum and field captures
//  and the probe timer for each item. A finished line or baud switch
//  becomes a job in a four-entry queue; bytes that cause no result never
//  enter the queue. The back checks time and date, updates fix, satellite
//  and lock registers and loads the output register. A result passes
//  through the queue and then the output register, where o_valid rises;
//  throughput is one item per cycle while the queue has room.
//  Output channel (o_valid/i_stall): the result holds while the receiver
//  stalls; the queue keeps absorbing jobs and stalls the input only when
//  four are waiting.
//  Reset (i_rst_n low, synchronous) clears all trackers, sets the baud from a
//  preload of 1 (fast), window 2500 ms. A write to register 1 restarts the
//  block with the new preload; register 0 sets the probe window.
module nmea_rmc_gga_parser_baud_probe import nrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_fix_valid,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [7:0]  o_satellites,
    output logic        o_baud_fast,
    output logic        o_baud_locked,
    output logic        o_baud_changed
);
    logic [15:0] r_window;
    logic        restart, push, full, qv, pop, decoded;
    t_job        job_in, job_out;
    t_lock       lock;
    t_res        res;

    assign restart = i_cfg_we && i_cfg_index == CFG_PRELOAD;

    // hold the window register; reset gives the default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_window <= 16'd2500;
        else if (i_cfg_we && i_cfg_index == CFG_WINDOW) r_window <= i_cfg_data;
    end

    nrp_front u_front (
        .i_clk, .i_rst_n, .i_restart(restart), .i_window(r_window),
        .i_valid, .o_stall, .i_op(i_operation), .i_byte(i_byte_value),
        .i_locked(lock.locked), .o_push(push), .o_job(job_in), .i_full(full),
        .o_decoded(decoded)
    );

    nrp_queue u_queue (
        .i_clk, .i_rst_n, .i_flush(restart), .i_push(push), .i_job(job_in),
        .o_full(full), .o_valid(qv), .o_job(job_out), .i_pop(pop)
    );

    nrp_back u_back (
        .i_clk, .i_rst_n, .i_restart(restart), .i_preload(i_cfg_data[0]),
        .i_valid(qv), .i_job(job_out), .o_pop(pop), .o_lock(lock),
        .o_valid, .i_stall, .o_res(res)
    );

    assign o_status       = res.status;
    assign o_fix_valid    = res.fix[0];
    assign o_hour         = res.fix[5:1];
    assign o_minute       = res.fix[11:6];
    assign o_second       = res.fix[17:12];
    assign o_year         = res.fix[29:18];
    assign o_month        = res.fix[33:30];
    assign o_day          = res.fix[38:34];
    assign o_satellites   = res.sat;
    assign o_baud_fast    = res.fast;
    assign o_baud_locked  = res.locked;
    assign o_baud_changed = res.changed;

    a_dec_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && job_in.kind == K_BAUD |-> !decoded) else $error("switch after decode");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> full) else $error("stall without full queue");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> !o_valid) else $error("result survived restart");
endmodule

>>> hdl/nrp_front.sv
// Front end: byte tracking, checksum, field capture and the baud probe timer.
// Uses nrp_pkg; produces t_job items into the queue.
module nrp_front import nrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic [15:0] i_window,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_byte,
    input  logic        i_locked,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full,
    output logic        o_decoded
);
    logic [7:0]  r_len, r_xor, r_sum, r_fcc;
    logic        r_dollar, r_star, r_act;
    logic [1:0]  r_hex, r_sst;
    logic [4:0]  r_fld;
    logic [23:0] r_tail, r_tcap, r_dcap;
    logic [8:0]  r_acc;
    logic [15:0] r_el;
    logic        r_seen, r_dec, r_lk;

    logic [7:0]  n_len, n_xor, n_sum, n_fcc;
    logic        n_dollar, n_star, n_act;
    logic [1:0]  n_hex, n_sst;
    logic [4:0]  n_fld;
    logic [23:0] n_tail, n_tcap, n_dcap;
    logic [8:0]  n_acc;
    logic [15:0] n_el;
    logic        n_seen, n_dec, n_lk;

    logic        acc, clr, rearm, good;
    logic [3:0]  d, hv;
    logic        hok;
    logic [23:0] tail_c;
    logic [12:0] mul;

    assign o_stall   = i_full;
    assign acc       = i_valid && !i_full;
    assign o_decoded = r_dec;

    always_comb begin
        n_len = r_len; n_xor = r_xor; n_sum = r_sum; n_fcc = r_fcc;
        n_dollar = r_dollar; n_star = r_star; n_act = r_act; n_hex = r_hex;
        n_sst = r_sst; n_fld = r_fld; n_tail = r_tail; n_tcap = r_tcap;
        n_dcap = r_dcap; n_acc = r_acc; n_el = r_el; n_seen = r_seen;
        n_dec = r_dec; n_lk = r_lk || i_locked;
        clr = 1'b0; rearm = 1'b0;
        o_push = 1'b0; o_job = '0; o_job.kind = K_LINE;
        d = (i_byte >= 8'd48 && i_byte <= 8'd57) ? i_byte[3:0] + 4'd1 : 4'd15;
        if (i_byte >= 8'd48 && i_byte <= 8'd57) begin
            d = 4'(i_byte - 8'd47);
        end
        hok = 1'b1; hv = '0;
        if (i_byte >= 8'd48 && i_byte <= 8'd57) hv = 4'(i_byte - 8'd48);
        else if (i_byte >= 8'd65 && i_byte <= 8'd70) hv = 4'(i_byte - 8'd55);
        else if (i_byte >= 8'd97 && i_byte <= 8'd102) hv = 4'(i_byte - 8'd87);
        else hok = 1'b0;
        tail_c = (r_fld == 5'd0 && r_fcc < 8'd3) ? 24'd0 : r_tail;
        good = r_dollar && r_star && r_hex == 2'd2 && r_xor == r_sum;
        mul = 13'(r_acc) * 13'd10 + 13'(d - 4'd1);
        if (acc && i_op) begin
            if (r_el != 16'hFFFF) n_el = r_el + 16'd1;
            if (!r_lk && !i_locked && r_seen && n_el >= i_window && !r_dec) begin
                rearm = 1'b1;
                n_lk = 1'b0;
                o_push = 1'b1;
                o_job.kind = K_BAUD;
            end
        end else if (acc) begin
            n_seen = 1'b1;
            if (i_byte == 8'd13 || i_byte == 8'd10) begin
                if (r_len != 8'd0) begin
                    clr = 1'b1;
                    o_push = 1'b1;
                    o_job.good = good;
                    o_job.is_rmc = r_tail == TAG_RMC && r_fld >= 5'd9;
                    o_job.is_gga = r_tail == TAG_GGA && r_fld >= 5'd7;
                    o_job.tcap = r_tcap; o_job.dcap = r_dcap; o_job.active = r_act;
                    o_job.sat_upd = r_sst != 2'd0;
                    o_job.sat_val = r_acc[8] ? 8'hFF : r_acc[7:0];
                    // a good line sets the lock view right away so no baud switch follows it
                    if (good) begin
                        n_dec = 1'b1;
                        n_lk = 1'b1;
                    end
                end
            end else if (i_byte >= 8'd32 && i_byte <= 8'd126) begin
                if (r_len >= 8'(LINE_MAX)) begin
                    clr = 1'b1;
                end else begin
                    n_len = r_len + 8'd1;
                    if (r_len == 8'd0) begin
                        n_dollar = i_byte == 8'd36;
                    end else if (!r_star) begin
                        if (i_byte == 8'd42) begin
                            n_star = 1'b1;
                            if (r_len == 8'd1) n_hex = 2'd3;
                            n_tail = tail_c;
                        end else begin
                            n_xor = r_xor ^ i_byte;
                            if (i_byte == 8'd44 && r_fld < 5'd19) begin
                                n_tail = tail_c;
                                n_fld = r_fld + 5'd1;
                                n_fcc = '0;
                            end else begin
                                case (r_fld)
                                    5'd0: n_tail = {r_tail[15:0], i_byte};
                                    5'd1: if (r_fcc < 8'd6)
                                        n_tcap[20-4*r_fcc[2:0] +: 4] = r_tcap[20-4*r_fcc[2:0] +: 4] | d;
                                    5'd2: n_act = r_fcc == 8'd0 && i_byte == 8'd65;
                                    5'd9: if (r_fcc < 8'd6)
                                        n_dcap[20-4*r_fcc[2:0] +: 4] = r_dcap[20-4*r_fcc[2:0] +: 4] | d;
                                    5'd7: begin
                                        if (r_sst <= 2'd1) begin
                                            if (i_byte == 8'd32) n_sst = 2'd1;
                                            else if (i_byte == 8'd43) begin
                                                n_sst = 2'd2; n_acc = '0;
                                            end else if (d <= 4'd10) begin
                                                n_sst = 2'd2; n_acc = 9'(d - 4'd1);
                                            end else begin
                                                n_sst = 2'd3; n_acc = '0;
                                            end
                                        end else if (r_sst == 2'd2) begin
                                            if (d <= 4'd10)
                                                n_acc = (mul > 13'd256) ? 9'd256 : mul[8:0];
                                            else n_sst = 2'd3;
                                        end
                                    end
                                    default: ;
                                endcase
                                if (r_fcc != 8'hFF) n_fcc = r_fcc + 8'd1;
                            end
                        end
                    end else if (r_hex < 2'd2) begin
                        if (!hok) n_hex = 2'd3;
                        else begin
                            n_sum = {r_sum[3:0], hv};
                            n_hex = r_hex + 2'd1;
                        end
                    end
                end
            end
        end
        if (clr || rearm) begin
            n_len = '0; n_xor = '0; n_dollar = 1'b0; n_star = 1'b0; n_hex = '0;
            n_sum = '0; n_fld = '0; n_fcc = '0; n_tail = '0; n_tcap = '0;
            n_dcap = '0; n_act = 1'b0; n_acc = '0; n_sst = '0;
        end
        if (rearm) begin
            n_el = '0; n_seen = 1'b0; n_dec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_len <= '0; r_xor <= '0; r_sum <= '0; r_fcc <= '0; r_dollar <= 1'b0;
            r_star <= 1'b0; r_act <= 1'b0; r_hex <= '0; r_sst <= '0; r_fld <= '0;
            r_tail <= '0; r_tcap <= '0; r_dcap <= '0; r_acc <= '0; r_el <= '0;
            r_seen <= 1'b0; r_dec <= 1'b0; r_lk <= 1'b0;
        end else begin
            r_len <= n_len; r_xor <= n_xor; r_sum <= n_sum; r_fcc <= n_fcc;
            r_dollar <= n_dollar; r_star <= n_star; r_act <= n_act; r_hex <= n_hex;
            r_sst <= n_sst; r_fld <= n_fld; r_tail <= n_tail; r_tcap <= n_tcap;
            r_dcap <= n_dcap; r_acc <= n_acc; r_el <= n_el; r_seen <= n_seen;
            r_dec <= n_dec; r_lk <= n_lk;
        end
    end
endmodule

>>> hdl/nrp_queue.sv
// Short FIFO of t_job items between front and back.
// Uses nrp_pkg.
module nrp_queue import nrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_flush,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);
    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QUEUE_AW{1'b0}}, i_push} - {{QUEUE_AW{1'b0}}, i_pop};
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
endmodule

>>> hdl/nrp_back.sv
// Back end: date/time checks, fix and satellite registers, lock, result register.
// Uses nrp_pkg; takes t_job items from the queue.
module nrp_back import nrp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_restart,
    input  logic  i_preload,
    input  logic  i_valid,
    input  t_job  i_job,
    output logic  o_pop,
    output t_lock o_lock,
    output logic  o_valid,
    input  logic  i_stall,
    output t_res  o_res
);
    logic [40:0] r_fix, n_fix;
    logic [7:0]  r_sat, n_sat;
    logic        r_fast, r_rep, r_lk, n_fast, n_rep, n_lk;
    logic        r_ov;
    t_res        r_res, n_res;
    logic        take;
    logic [3:0]  h1, h0, m1, m0, s1, s0, d1, d0, o1, o0, y1, y0;
    logic [6:0]  hh, dd;
    logic [6:0]  mi, ss;
    logic [6:0]  mo;
    logic [6:0]  yy;
    logic [11:0] yr;
    logic        dig, ok, lp, chg;
    logic [4:0]  lim;

    assign take    = i_valid && (!r_ov || !i_stall);
    assign o_pop   = take;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign o_lock  = '{locked: r_lk, fast: r_fast};

    always_comb begin
        h1 = cap_dig(i_job.tcap, 0); h0 = cap_dig(i_job.tcap, 1);
        m1 = cap_dig(i_job.tcap, 2); m0 = cap_dig(i_job.tcap, 3);
        s1 = cap_dig(i_job.tcap, 4); s0 = cap_dig(i_job.tcap, 5);
        d1 = cap_dig(i_job.dcap, 0); d0 = cap_dig(i_job.dcap, 1);
        o1 = cap_dig(i_job.dcap, 2); o0 = cap_dig(i_job.dcap, 3);
        y1 = cap_dig(i_job.dcap, 4); y0 = cap_dig(i_job.dcap, 5);
        dig = h1 != 4'd15 && h0 != 4'd15 && m1 != 4'd15 && m0 != 4'd15 &&
              s1 != 4'd15 && s0 != 4'd15 && d1 != 4'd15 && d0 != 4'd15 &&
              o1 != 4'd15 && o0 != 4'd15 && y1 != 4'd15 && y0 != 4'd15;
        hh = 7'(h1) * 7'd10 + 7'(h0);
        mi = 7'(m1) * 7'd10 + 7'(m0);
        ss = 7'(s1) * 7'd10 + 7'(s0);
        dd = 7'(d1) * 7'd10 + 7'(d0);
        mo = 7'(o1) * 7'd10 + 7'(o0);
        yy = 7'(y1) * 7'd10 + 7'(y0);
        yr = 12'd2000 + 12'(yy);
        lp = yy[1:0] == 2'b00;
        case (mo)
            7'd2:                    lim = lp ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11: lim = 5'd30;
            default:                 lim = 5'd31;
        endcase
        ok = i_job.active && dig && d1 <= 4'd3 && o1 <= 4'd1 && h1 <= 4'd2 &&
             hh <= 7'd23 && mi <= 7'd59 && ss <= 7'd59 && yy >= 7'd24 &&
             mo >= 7'd1 && mo <= 7'd12 && dd >= 7'd1 && dd <= {2'b00, lim};

        n_fix = r_fix; n_sat = r_sat; n_fast = r_fast; n_rep = r_rep; n_lk = r_lk;
        n_res = r_res; chg = 1'b0;
        if (take) begin
            if (i_job.kind == K_BAUD) begin
                n_fast = !r_fast;
                n_lk = 1'b0;
                n_res.status = ST_BAUD;
            end else if (!i_job.good) begin
                n_res.status = ST_REJECT;
            end else begin
                n_res.status = ST_OTHER;
                if (i_job.is_rmc) begin
                    n_res.status = ST_RMC;
                    n_fix = ok ? {2'b00, dd[4:0], mo[3:0], yr, ss[5:0], mi[5:0], hh[4:0], 1'b1}
                               : 41'd0;
                end else if (i_job.is_gga) begin
                    n_res.status = ST_GGA;
                    if (i_job.sat_upd) n_sat = i_job.sat_val;
                end
                if (!r_lk) begin
                    n_lk = 1'b1;
                    if (r_fast != r_rep) begin
                        n_rep = r_fast; chg = 1'b1;
                    end
                end
            end
            n_res.fix = n_fix; n_res.sat = n_sat; n_res.fast = n_fast;
            n_res.locked = n_lk; n_res.changed = chg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fix <= '0; r_sat <= '0; r_lk <= 1'b0; r_ov <= 1'b0;
            r_fast <= i_rst_n ? i_preload : 1'b1;
            r_rep  <= i_rst_n ? i_preload : 1'b1;
        end else begin
            r_fix <= n_fix; r_sat <= n_sat; r_fast <= n_fast; r_rep <= n_rep;
            r_lk <= n_lk;
            if (take) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_restart)
        r_ov && i_stall |=> r_ov) else $error("result dropped under stall");
    a_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fix[0] == 1'b0 |-> r_fix == 41'd0) else $error("fix fields without fix");
    a_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_res.changed |-> r_res.locked) else $error("change without lock");
endmodule
